// ===== design/vig52_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vig52_pkg
// Types, codes and letter helpers for the 52-letter Vigenere cipher core.
// ----------------------------------------------------------------------------
package vig52_pkg;

    typedef logic [7:0] t_byte;
    typedef logic [5:0] t_letter;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_CIPHER = 1'b1;

    localparam logic CFG_KEY_LENGTH   = 1'b0;
    localparam logic CFG_DECRYPT_MODE = 1'b1;

    localparam t_letter ALPHA_SIZE = 6'd52;
    localparam t_letter HALF_SIZE  = 6'd26;
    localparam t_byte   UPPER_BASE = 8'h41;
    localparam t_byte   LOWER_BASE = 8'h61;

    function automatic logic is_letter(input t_byte c);
        return ((c >= 8'h41) && (c <= 8'h5a)) || ((c >= 8'h61) && (c <= 8'h7a));
    endfunction

    function automatic t_letter letter_index(input t_byte c);
        t_byte d;
        if (c <= 8'h5a) begin
            d = c - UPPER_BASE;
        end else begin
            d = c - LOWER_BASE + 8'(HALF_SIZE);
        end
        return d[5:0];
    endfunction

    function automatic t_byte index_letter(input t_letter v);
        if (v < HALF_SIZE) begin
            return UPPER_BASE + {2'b00, v};
        end
        return LOWER_BASE + {2'b00, v} - 8'(HALF_SIZE);
    endfunction

endpackage
`default_nettype wire

// ===== design/vigenere_52_letter_cipher_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vigenere_52_letter_cipher_core
// Vigenere cipher over A-Z then a-z with a loadable key store.
// ----------------------------------------------------------------------------
// a text item is registered in stage one, then in the output register, before its result item
// throughput: one item per cycle while the output is not stalled; the key store read is registered in stage one
// key load items write the store and produce no result
// reset clears the key position, key_length to 1 and decrypt_mode to 0
// the key store is not reset and holds nothing meaningful until written
module vigenere_52_letter_cipher_core #(
    parameter int KEY_DEPTH = 256
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire                 i_cfg_index,
    input  wire  [8:0]          i_cfg_data,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  wire                 i_opcode,
    input  wire  [7:0]          i_data_byte,
    input  wire  [7:0]          i_key_slot,
    input  wire                 i_last_in_message,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output vig52_pkg::t_byte    o_result_byte,
    output logic                o_result_last
);
    import vig52_pkg::*;

    localparam int AW      = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam int LEN_CAP = (KEY_DEPTH < 256) ? KEY_DEPTH : 256;
    localparam logic [8:0]  LEN_MAX   = 9'(LEN_CAP);
    localparam logic [12:0] DEPTH_LIM = 13'(KEY_DEPTH);

    t_byte       mem [KEY_DEPTH];

    logic [8:0]  r_key_length;
    logic        r_decrypt_mode;
    logic [7:0]  r_pos;
    logic        r_s1_valid;
    t_byte       r_s1_text;
    logic        r_s1_last;
    t_byte       r_key;
    logic        r_out_valid;
    t_byte       r_out_byte;
    logic        r_out_last;

    logic [8:0]  w_len;
    logic [7:0]  w_pos_eff;
    logic [8:0]  w_pos_inc;
    logic [7:0]  n_pos;
    logic [11:0] w_rd_ext;
    logic [11:0] w_wr_ext;
    logic [AW-1:0] w_rd_addr;
    logic [AW-1:0] w_wr_addr;
    logic        w_accept;
    logic        w_s1_move;
    logic        w_wr_en;
    logic        w_rd_en;
    t_letter     w_t;
    t_letter     w_k;
    logic [6:0]  w_sum;
    t_letter     w_v;
    t_byte       n_out_byte;

    assign o_cfg_ready = 1'b1;

    assign w_s1_move  = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_wr_en    = w_accept && (i_opcode == OP_LOAD) && ({5'b0, i_key_slot} < DEPTH_LIM);
    assign w_rd_en    = w_accept && (i_opcode == OP_CIPHER);

    // effective key length and position
    always_comb begin
        w_len = r_key_length;
        if (w_len == 9'd0) begin
            w_len = 9'd1;
        end
        if (w_len > LEN_MAX) begin
            w_len = LEN_MAX;
        end
        w_pos_eff = ({1'b0, r_pos} >= w_len) ? 8'd0 : r_pos;
        w_pos_inc = {1'b0, w_pos_eff} + 9'd1;
        if (i_last_in_message || (w_pos_inc >= w_len)) begin
            n_pos = 8'd0;
        end else begin
            n_pos = w_pos_inc[7:0];
        end
    end

    assign w_rd_ext  = {4'b0, w_pos_eff};
    assign w_wr_ext  = {4'b0, i_key_slot};
    assign w_rd_addr = w_rd_ext[AW-1:0];
    assign w_wr_addr = w_wr_ext[AW-1:0];

    // key store
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[w_wr_addr] <= i_data_byte;
        end
        if (w_rd_en) begin
            r_key     <= mem[w_rd_addr];
            r_s1_text <= i_data_byte;
            r_s1_last <= i_last_in_message;
        end
    end

    // letter arithmetic
    always_comb begin
        w_t = letter_index(r_s1_text);
        w_k = letter_index(r_key);
        if (r_decrypt_mode) begin
            w_sum = {1'b0, w_t} + 7'(ALPHA_SIZE) - {1'b0, w_k};
        end else begin
            w_sum = {1'b0, w_t} + {1'b0, w_k};
        end
        if (w_sum >= 7'(ALPHA_SIZE)) begin
            w_sum = w_sum - 7'(ALPHA_SIZE);
        end
        w_v = w_sum[5:0];
        if (is_letter(r_s1_text) && is_letter(r_key)) begin
            n_out_byte = index_letter(w_v);
        end else begin
            n_out_byte = r_s1_text;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_length   <= 9'd1;
            r_decrypt_mode <= 1'b0;
            r_pos          <= 8'd0;
            r_s1_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_KEY_LENGTH:   r_key_length   <= i_cfg_data;
                    CFG_DECRYPT_MODE: r_decrypt_mode <= i_cfg_data[0];
                    default:          r_key_length   <= r_key_length;
                endcase
            end
            if (w_rd_en) begin
                r_pos <= n_pos;
            end
            if (w_rd_en) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_move) begin
            r_out_byte <= n_out_byte;
            r_out_last <= r_s1_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_result_byte = r_out_byte;
    assign o_result_last = r_out_last;

endmodule
`default_nettype wire

// ===== design/vig52_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vig52_checker
// Port-level checks for the cipher core, bound to the top level.
// ----------------------------------------------------------------------------
module vig52_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_in_valid,
    input wire       o_in_ready,
    input wire       i_opcode,
    input wire       o_out_valid,
    input wire       i_out_ready,
    input wire [7:0] o_result_byte,
    input wire       o_result_last
);
    import vig52_pkg::*;

    // reset empties the output
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output item present after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_result_byte) && $stable(o_result_last))
        else $error("stalled result item changed");

    // input only stalls behind a full output
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with output empty");

    // a new result comes from an accepted text item that passed through stage one
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready && (i_opcode == OP_CIPHER), 2))
        else $error("result item without a text item");

endmodule

bind vigenere_52_letter_cipher_core vig52_checker u_vig52_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .i_opcode      (i_opcode),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_result_byte (o_result_byte),
    .o_result_last (o_result_last)
);
`default_nettype wire

// ===== sim/vigenere_52_letter_cipher_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vigenere_52_letter_cipher_core_test
// Self-checking bench for the 52-letter Vigenere core: directed key loads and
// text bytes, then random phases under several register settings and flow
// patterns, each result item checked against a cycle-free predictor.
// ----------------------------------------------------------------------------
module vigenere_52_letter_cipher_core_test;
    import vig52_pkg::*;

    localparam int STORE_SIZE  = 256;
    localparam int SETTLE      = 8;
    localparam int STALL_LIMIT = 2000;
    localparam int SHOW_LIMIT  = 10;

    localparam t_byte UP_A = 8'h41;
    localparam t_byte UP_Z = 8'h5a;
    localparam t_byte LO_A = 8'h61;
    localparam t_byte LO_Z = 8'h7a;

    typedef enum int {FLOW_FREE, FLOW_SEND_GAPS, FLOW_SINK_STALL, FLOW_BOTH} flow_t;

    typedef struct {
        logic  op;
        t_byte data;
        t_byte slot;
        logic  last;
    } cipher_item_t;

    typedef struct {
        t_byte text;
        logic  last;
    } cipher_out_t;

    logic       i_clk             = 1'b0;
    logic       i_rst_n           = 1'b0;
    logic       i_cfg_valid       = 1'b0;
    logic       i_cfg_index       = CFG_KEY_LENGTH;
    logic [8:0] i_cfg_data        = '0;
    logic       i_in_valid        = 1'b0;
    logic       i_opcode          = OP_LOAD;
    logic [7:0] i_data_byte       = '0;
    logic [7:0] i_key_slot        = '0;
    logic       i_last_in_message = 1'b0;
    logic       i_out_ready       = 1'b0;
    wire        o_cfg_ready;
    wire        o_in_ready;
    wire        o_out_valid;
    wire  [7:0] o_result_byte;
    wire        o_result_last;

    vigenere_52_letter_cipher_core uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_opcode          (i_opcode),
        .i_data_byte       (i_data_byte),
        .i_key_slot        (i_key_slot),
        .i_last_in_message (i_last_in_message),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_result_byte     (o_result_byte),
        .o_result_last     (o_result_last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    cipher_item_t text_stream[$];
    cipher_out_t  awaited_out[$];

    // predictor state, follows accepted items
    t_byte      key_mirror [STORE_SIZE];
    int         pos_mirror = 0;
    logic [8:0] len_mirror = 9'd1;
    logic       dec_mirror = 1'b0;

    // stimulus planning state, keeps reads away from unwritten key entries
    logic [8:0] plan_len = 9'd1;
    int         plan_pos = 0;
    bit         plan_written [STORE_SIZE];

    flow_t flow         = FLOW_FREE;
    int    items_queued = 0;
    int    items_taken  = 0;
    int    mismatches   = 0;
    int    quiet_cycles = 0;
    bit    in_took      = 1'b0;

    function automatic int alpha_pos(input t_byte c);
        if (c >= UP_A && c <= UP_Z) begin
            return int'(c - UP_A);
        end
        if (c >= LO_A && c <= LO_Z) begin
            return int'(c - LO_A) + 26;
        end
        return -1;
    endfunction

    function automatic t_byte letter_at(input int v);
        return (v < 26) ? t_byte'(UP_A + v) : t_byte'(LO_A + v - 26);
    endfunction

    function automatic int eff_len(input logic [8:0] n);
        if (n == 9'd0) begin
            return 1;
        end
        if (int'(n) > STORE_SIZE) begin
            return STORE_SIZE;
        end
        return int'(n);
    endfunction

    function automatic t_byte shift_letter(input t_byte txt, input t_byte key,
                                           input logic dec);
        int t;
        int k;
        int v;
        t = alpha_pos(txt);
        k = alpha_pos(key);
        if (t < 0 || k < 0) begin
            return txt;
        end
        v = dec ? (t - k + 52) % 52 : (t + k) % 52;
        return letter_at(v);
    endfunction

    function automatic t_byte pick_byte();
        if ($urandom_range(0, 99) < 70) begin
            return letter_at($urandom_range(0, 51));
        end
        return t_byte'($urandom_range(0, 255));
    endfunction

    function automatic void queue_load(input t_byte slot, input t_byte key);
        text_stream.push_back('{op: OP_LOAD, data: key, slot: slot,
                                last: logic'($urandom_range(0, 1))});
        plan_written[slot] = 1'b1;
        items_queued++;
    endfunction

    function automatic void queue_text(input t_byte txt, input logic last);
        int n;
        int p;
        n = eff_len(plan_len);
        p = (plan_pos >= n) ? 0 : plan_pos;
        if (!plan_written[p]) begin
            queue_load(t_byte'(p), letter_at($urandom_range(0, 51)));
        end
        text_stream.push_back('{op: OP_CIPHER, data: txt,
                                slot: t_byte'($urandom_range(0, 255)), last: last});
        items_queued++;
        plan_pos = last ? 0 : ((p + 1 >= n) ? 0 : p + 1);
    endfunction

    task automatic fill_random(input int count);
        int n;
        n = eff_len(plan_len);
        repeat (count) begin
            if ($urandom_range(0, 99) < 18) begin
                if ($urandom_range(0, 1) == 1) begin
                    queue_load(t_byte'($urandom_range(0, n - 1)), pick_byte());
                end else begin
                    queue_load(t_byte'($urandom_range(0, 255)), pick_byte());
                end
            end else begin
                queue_text(pick_byte(), $urandom_range(0, 11) == 0);
            end
        end
        // leave the key position mid-message for the next setting
        repeat (3) queue_text(pick_byte(), 1'b0);
    endtask

    task automatic wait_quiet();
        do begin
            @(negedge i_clk);
        end while (text_stream.size() != 0 || items_taken != items_queued ||
                   awaited_out.size() != 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [8:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic start_phase(input logic [8:0] len, input logic dec, input flow_t mode);
        wait_quiet();
        write_reg(CFG_KEY_LENGTH, len);
        write_reg(CFG_DECRYPT_MODE, {8'd0, dec});
        plan_len = len;
        flow     = mode;
    endtask

    // driver: inputs move on the falling edge
    always @(negedge i_clk) begin : drive
        cipher_item_t nxt;
        bit gap;
        bit stall;
        gap   = (flow == FLOW_SEND_GAPS) ? ($urandom_range(0, 99) < 76) :
                (flow == FLOW_BOTH)      ? ($urandom_range(0, 99) < 28) : 1'b0;
        stall = (flow == FLOW_SINK_STALL) ? ($urandom_range(0, 99) < 76) :
                (flow == FLOW_BOTH)       ? ($urandom_range(0, 99) < 28) : 1'b0;
        if (!i_in_valid || in_took) begin
            if (text_stream.size() > 0 && !gap) begin
                nxt = text_stream.pop_front();
                i_in_valid        <= 1'b1;
                i_opcode          <= nxt.op;
                i_data_byte       <= nxt.data;
                i_key_slot        <= nxt.slot;
                i_last_in_message <= nxt.last;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_ready <= !stall;
    end

    // monitor: handshakes sampled on the rising edge
    always @(posedge i_clk) begin : watch
        cipher_out_t want;
        int n;
        int p;
        bit moved;
        in_took = i_in_valid && o_in_ready;
        moved   = 1'b0;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                moved = 1'b1;
                if (i_cfg_index == CFG_KEY_LENGTH) begin
                    len_mirror = i_cfg_data;
                end else begin
                    dec_mirror = i_cfg_data[0];
                end
            end
            if (o_out_valid && i_out_ready) begin
                moved = 1'b1;
                if (awaited_out.size() == 0) begin
                    mismatches++;
                    if (mismatches <= SHOW_LIMIT) begin
                        $display("unexpected result item: byte %h last %b",
                                 o_result_byte, o_result_last);
                    end
                end else begin
                    want = awaited_out.pop_front();
                    if (o_result_byte !== want.text || o_result_last !== want.last) begin
                        mismatches++;
                        if (mismatches <= SHOW_LIMIT) begin
                            $display("result mismatch: expected byte %h last %b, got byte %h last %b",
                                     want.text, want.last, o_result_byte, o_result_last);
                        end
                    end
                end
            end
            if (in_took) begin
                moved = 1'b1;
                items_taken++;
                if (i_opcode == OP_LOAD) begin
                    key_mirror[i_key_slot] = i_data_byte;
                end else begin
                    n = eff_len(len_mirror);
                    p = (pos_mirror >= n) ? 0 : pos_mirror;
                    awaited_out.push_back('{text: shift_letter(i_data_byte, key_mirror[p],
                                                               dec_mirror),
                                            last: i_last_in_message});
                    pos_mirror = i_last_in_message ? 0 : ((p + 1 >= n) ? 0 : p + 1);
                end
            end
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // three key letters: shift of nothing, shift of 51, and a non-letter key
        start_phase(9'd3, 1'b0, FLOW_FREE);
        queue_load(8'd0, UP_A);
        queue_load(8'd1, LO_Z);
        queue_load(8'd2, 8'hff);
        queue_load(8'd255, 8'h4d);
        queue_text(UP_Z, 1'b0);
        queue_text(LO_Z, 1'b0);
        queue_text(LO_A, 1'b0);
        queue_text(8'h00, 1'b0);
        queue_text(8'hff, 1'b0);
        queue_text(8'h40, 1'b0);
        queue_text(8'h5b, 1'b0);
        queue_text(8'h60, 1'b0);
        queue_text(8'h7b, 1'b0);
        queue_text(UP_A, 1'b1);
        queue_text(UP_A, 1'b0);
        queue_load(8'd1, LO_A);
        queue_text(UP_Z, 1'b0);

        // zero length lands mid-message, so the position is folded back to the start
        start_phase(9'd0, 1'b1, FLOW_BOTH);
        queue_text(UP_Z, 1'b0);
        queue_load(8'd0, 8'h62);
        queue_text(UP_A, 1'b0);
        queue_text(LO_A, 1'b0);
        queue_text(LO_Z, 1'b1);

        start_phase(9'd4, 1'b0, FLOW_FREE);
        fill_random(200);
        start_phase(9'd256, 1'b1, FLOW_SEND_GAPS);
        fill_random(200);
        start_phase(9'd0, 1'b0, FLOW_SINK_STALL);
        fill_random(180);
        start_phase(9'd511, 1'b1, FLOW_BOTH);
        fill_random(200);
        start_phase(9'd1, 1'b1, FLOW_FREE);
        fill_random(150);
        start_phase(9'd300, 1'b0, FLOW_SEND_GAPS);
        fill_random(200);
        start_phase(9'd17, 1'b1, FLOW_SINK_STALL);
        fill_random(200);
        start_phase(9'd2, 1'b0, FLOW_BOTH);
        fill_random(150);

        wait_quiet();
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
